@@ hdl/assert_macros.svh @@
// Assertion macros shared by the stick gesture arming design.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SGAF_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high.
`define SGAF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

@@ hdl/sgaf_pkg.sv @@
// Package of the stick gesture arming design: types, register indexes and constants.
// Depends on nothing; imported by every module of the design.
package sgaf_pkg;

   localparam int PULSE_W = 12;
   localparam int HOLD_W  = 16;
   localparam int TICK_W  = 32;
   localparam int STATE_W = 3;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_ARM_HOLD     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DISARM_HOLD  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ESC_CAL_HOLD = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_STICK_LOW    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_STICK_HIGH   = 3'd4;

   localparam logic [HOLD_W-1:0]  ARM_HOLD_RST     = 16'd1000;
   localparam logic [HOLD_W-1:0]  DISARM_HOLD_RST  = 16'd1000;
   localparam logic [HOLD_W-1:0]  ESC_CAL_HOLD_RST = 16'd2000;
   localparam logic [PULSE_W-1:0] STICK_LOW_RST    = 12'd1100;
   localparam logic [PULSE_W-1:0] STICK_HIGH_RST   = 12'd1900;

   localparam logic [PULSE_W-1:0] ROLL_MID_LO = 12'd1400;
   localparam logic [PULSE_W-1:0] ROLL_MID_HI = 12'd1600;
   localparam logic [PULSE_W-1:0] SAFE_LO     = 12'd1450;
   localparam logic [PULSE_W-1:0] SAFE_HI     = 12'd1550;

   typedef struct packed {
      logic [HOLD_W-1:0]  arm_hold_ms;
      logic [HOLD_W-1:0]  disarm_hold_ms;
      logic [HOLD_W-1:0]  esc_cal_hold_ms;
      logic [PULSE_W-1:0] stick_low_limit;
      logic [PULSE_W-1:0] stick_high_limit;
   } cfg_type;

   typedef struct packed {
      logic [PULSE_W-1:0] throttle_pulse;
      logic [PULSE_W-1:0] yaw_pulse;
      logic [PULSE_W-1:0] pitch_pulse;
      logic [PULSE_W-1:0] roll_pulse;
      logic [TICK_W-1:0]  now_ms;
   } sample_type;

   typedef struct packed {
      logic arm;
      logic disarm;
      logic esc_cal;
      logic motor;
      logic safe;
   } gesture_type;

endpackage

@@ hdl/sgaf_gesture.sv @@
// Sorts one registered stick sample into the five stick gestures.
// Depends on sgaf_pkg for the sample, configuration and gesture types.
module sgaf_gesture
   import sgaf_pkg::*;
(
   input  sample_type  sample,
   input  cfg_type     cfg,
   output gesture_type gesture
);

   logic thr_low, thr_high, yaw_low, yaw_high, pit_high, rol_low, rol_high;
   logic roll_mid, yaw_ctr, pit_ctr, rol_ctr;

   assign thr_low  = sample.throttle_pulse < cfg.stick_low_limit;
   assign thr_high = sample.throttle_pulse > cfg.stick_high_limit;
   assign yaw_low  = sample.yaw_pulse < cfg.stick_low_limit;
   assign yaw_high = sample.yaw_pulse > cfg.stick_high_limit;
   assign pit_high = sample.pitch_pulse > cfg.stick_high_limit;
   assign rol_low  = sample.roll_pulse < cfg.stick_low_limit;
   assign rol_high = sample.roll_pulse > cfg.stick_high_limit;

   assign roll_mid = (sample.roll_pulse > ROLL_MID_LO) && (sample.roll_pulse < ROLL_MID_HI);
   assign yaw_ctr  = (sample.yaw_pulse >= SAFE_LO) && (sample.yaw_pulse <= SAFE_HI);
   assign pit_ctr  = (sample.pitch_pulse >= SAFE_LO) && (sample.pitch_pulse <= SAFE_HI);
   assign rol_ctr  = (sample.roll_pulse >= SAFE_LO) && (sample.roll_pulse <= SAFE_HI);

   always_comb begin
      gesture.arm     = thr_low && yaw_high && pit_high && rol_low;
      gesture.disarm  = thr_low && yaw_low && pit_high && rol_high;
      gesture.esc_cal = thr_low && yaw_low && pit_high && roll_mid;
      gesture.motor   = thr_high && yaw_low && pit_high && roll_mid;
      gesture.safe    = thr_low && yaw_ctr && pit_ctr && rol_ctr;
   end

endmodule

@@ hdl/sgaf_fsm.sv @@
// Arming state machine with hold timers and the registered result word.
// Depends on sgaf_pkg and assert_macros.svh.
`include "assert_macros.svh"
module sgaf_fsm
   import sgaf_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  gesture_type        gesture,
   input  logic [TICK_W-1:0]  now_ms,
   input  cfg_type            cfg,
   output logic [STATE_W-1:0] arm_state,
   output logic               esc_cal_request,
   output logic               arm_done_pulse
);

   typedef enum logic [STATE_W-1:0] {
      DISARMED    = 3'd0,
      ARMING      = 3'd1,
      ARMED_WAIT  = 3'd2,
      ARMED       = 3'd3,
      DISARMING   = 3'd4,
      ESC_CAL     = 3'd5,
      MOTOR_CHECK = 3'd6
   } mode_type;

   mode_type          mode_ff, mode_in;
   logic [TICK_W-1:0] hold_start_ff, hold_start_in;
   logic              esc_flag_ff, esc_flag_in;
   logic              pulse_ff, pulse_in;
   logic [TICK_W-1:0] elapsed;
   logic              arm_held, disarm_held, esc_held;

   assign elapsed     = now_ms - hold_start_ff;
   assign arm_held    = elapsed >= {{(TICK_W-HOLD_W){1'b0}}, cfg.arm_hold_ms};
   assign disarm_held = elapsed >= {{(TICK_W-HOLD_W){1'b0}}, cfg.disarm_hold_ms};
   assign esc_held    = elapsed >= {{(TICK_W-HOLD_W){1'b0}}, cfg.esc_cal_hold_ms};

   always_comb begin
      mode_in       = mode_ff;
      hold_start_in = hold_start_ff;
      esc_flag_in   = esc_flag_ff;
      pulse_in      = 1'b0;
      unique case (mode_ff)
         DISARMED: begin
            priority if (gesture.arm) begin
               hold_start_in = now_ms;
               mode_in       = ARMING;
            end else if (gesture.esc_cal) begin
               hold_start_in = now_ms;
               mode_in       = ESC_CAL;
            end else if (gesture.motor) begin
               mode_in = MOTOR_CHECK;
            end else begin
               mode_in = DISARMED;
            end
         end
         ESC_CAL: begin
            if (gesture.esc_cal && esc_held) begin
               esc_flag_in = 1'b1;
            end
         end
         ARMING: begin
            if (!gesture.arm) begin
               mode_in = DISARMED;
            end else if (arm_held) begin
               mode_in  = ARMED_WAIT;
               pulse_in = 1'b1;
            end
         end
         ARMED_WAIT: begin
            if (gesture.safe) begin
               mode_in = ARMED;
            end
         end
         ARMED: begin
            if (gesture.disarm) begin
               hold_start_in = now_ms;
               mode_in       = DISARMING;
            end
         end
         DISARMING: begin
            if (!gesture.disarm) begin
               mode_in = ARMED;
            end else if (disarm_held) begin
               mode_in = DISARMED;
            end
         end
         default: begin
            mode_in = mode_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= DISARMED;
         hold_start_ff <= '0;
         esc_flag_ff   <= 1'b0;
         pulse_ff      <= 1'b0;
      end else if (step) begin
         mode_ff       <= mode_in;
         hold_start_ff <= hold_start_in;
         esc_flag_ff   <= esc_flag_in;
         pulse_ff      <= pulse_in;
      end
   end

   assign arm_state       = mode_ff;
   assign esc_cal_request = esc_flag_ff;
   assign arm_done_pulse  = pulse_ff;

   `SGAF_ASSERT_SAME(a_pulse_in_wait, clock, reset, pulse_ff, mode_ff == ARMED_WAIT)
   `SGAF_ASSERT_SAME(a_esc_flag_mode, clock, reset, esc_flag_ff, mode_ff == ESC_CAL)
   `SGAF_ASSERT_NEXT(a_esc_flag_sticky, clock, reset, esc_flag_ff, esc_flag_ff)
   `SGAF_ASSERT_NEXT(a_motor_kept, clock, reset, mode_ff == MOTOR_CHECK, mode_ff == MOTOR_CHECK)
   `SGAF_ASSERT_NEXT(a_idle_holds, clock, reset, !step, $stable(mode_ff) && $stable(pulse_ff))

endmodule

@@ hdl/stick_gesture_arming_fsm.sv @@
// A sample word is held in the input register, and its result word is written
// into the result register once that is free. Throughput: one sample word per
// cycle unless the result side stalls; compare and state update sit between them.
// Reset (synchronous): state disarmed, hold start zero, calibration flag clear,
// configuration registers back to their default hold times and limits.
module stick_gesture_arming_fsm
   import sgaf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [PULSE_W-1:0]    req_throttle_pulse,
   input  logic [PULSE_W-1:0]    req_yaw_pulse,
   input  logic [PULSE_W-1:0]    req_pitch_pulse,
   input  logic [PULSE_W-1:0]    req_roll_pulse,
   input  logic [TICK_W-1:0]     req_now_ms,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [STATE_W-1:0]    rsp_arm_state,
   output logic                  rsp_esc_cal_request,
   output logic                  rsp_arm_done_pulse,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   cfg_type     cfg_ff;
   sample_type  sample_ff;
   logic        in_valid_ff;
   logic        out_valid_ff;
   logic        step;
   gesture_type gesture;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.arm_hold_ms      <= ARM_HOLD_RST;
         cfg_ff.disarm_hold_ms   <= DISARM_HOLD_RST;
         cfg_ff.esc_cal_hold_ms  <= ESC_CAL_HOLD_RST;
         cfg_ff.stick_low_limit  <= STICK_LOW_RST;
         cfg_ff.stick_high_limit <= STICK_HIGH_RST;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_ARM_HOLD:     cfg_ff.arm_hold_ms     <= csr_write_data;
            CSR_DISARM_HOLD:  cfg_ff.disarm_hold_ms  <= csr_write_data;
            CSR_ESC_CAL_HOLD: cfg_ff.esc_cal_hold_ms <= csr_write_data;
            CSR_STICK_LOW:    cfg_ff.stick_low_limit  <= csr_write_data[PULSE_W-1:0];
            CSR_STICK_HIGH:   cfg_ff.stick_high_limit <= csr_write_data[PULSE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign step      = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || step;
   assign rsp_valid = out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (step) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         sample_ff.throttle_pulse <= req_throttle_pulse;
         sample_ff.yaw_pulse      <= req_yaw_pulse;
         sample_ff.pitch_pulse    <= req_pitch_pulse;
         sample_ff.roll_pulse     <= req_roll_pulse;
         sample_ff.now_ms         <= req_now_ms;
      end
   end

   sgaf_gesture u_gesture (
      .sample  (sample_ff),
      .cfg     (cfg_ff),
      .gesture (gesture)
   );

   sgaf_fsm u_fsm (
      .clock           (clock),
      .reset           (reset),
      .step            (step),
      .gesture         (gesture),
      .now_ms          (sample_ff.now_ms),
      .cfg             (cfg_ff),
      .arm_state       (rsp_arm_state),
      .esc_cal_request (rsp_esc_cal_request),
      .arm_done_pulse  (rsp_arm_done_pulse)
   );

endmodule

@@ dv/tb_stick_gesture_arming_fsm.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the stick gesture arming state machine.
// Depends on sgaf_pkg and stick_gesture_arming_fsm, with the files that module depends on.
module tb_stick_gesture_arming_fsm;
   import sgaf_pkg::*;

   typedef enum logic [STATE_W-1:0] {
      MODE_DISARMED    = 3'd0,
      MODE_ARMING      = 3'd1,
      MODE_ARMED_WAIT  = 3'd2,
      MODE_ARMED       = 3'd3,
      MODE_DISARMING   = 3'd4,
      MODE_ESC_CAL     = 3'd5,
      MODE_MOTOR_CHECK = 3'd6
   } arm_mode_type;

   typedef enum {G_ARM, G_DISARM, G_ESC, G_MOTOR, G_SAFE, G_IDLE, G_NOISE} gesture_kind_type;

   typedef struct packed {
      arm_mode_type mode;
      logic         cal;
      logic         done;
   } arm_status_type;

   typedef struct packed {
      sample_type     smp;
      logic           typed;
      arm_status_type want;
   } directed_row_type;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DIR_ROWS = 25;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [PULSE_W-1:0]    req_throttle_pulse;
   logic [PULSE_W-1:0]    req_yaw_pulse;
   logic [PULSE_W-1:0]    req_pitch_pulse;
   logic [PULSE_W-1:0]    req_roll_pulse;
   logic [TICK_W-1:0]     req_now_ms;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [STATE_W-1:0]    rsp_arm_state;
   logic                  rsp_esc_cal_request;
   logic                  rsp_arm_done_pulse;
   logic                  csr_write_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   stick_gesture_arming_fsm dut (.*);

   // Shadow copy of the block: registers, state, hold start and sticky flag.
   cfg_type          shadow_cfg;
   arm_mode_type     shadow_mode;
   logic [TICK_W-1:0] shadow_hold_start;
   logic             shadow_cal;

   arm_status_type   status_q[$];
   arm_status_type   due;
   directed_row_type dir_rows[DIR_ROWS];
   logic [TICK_W-1:0] tick_ms;
   int               mismatches;
   int               quiet_cycles;
   int               words_sent;
   int               arm_completions;
   int               settings_used;
   bit               sender_burst;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic gesture_type decode_gestures(sample_type s);
      gesture_type g;
      logic [PULSE_W-1:0] lo;
      logic [PULSE_W-1:0] hi;
      logic roll_mid;
      lo = shadow_cfg.stick_low_limit;
      hi = shadow_cfg.stick_high_limit;
      roll_mid = s.roll_pulse > ROLL_MID_LO && s.roll_pulse < ROLL_MID_HI;
      g.arm = s.throttle_pulse < lo && s.yaw_pulse > hi && s.pitch_pulse > hi
              && s.roll_pulse < lo;
      g.disarm = s.throttle_pulse < lo && s.yaw_pulse < lo && s.pitch_pulse > hi
                 && s.roll_pulse > hi;
      g.esc_cal = s.throttle_pulse < lo && s.yaw_pulse < lo && s.pitch_pulse > hi
                  && roll_mid;
      g.motor = s.throttle_pulse > hi && s.yaw_pulse < lo && s.pitch_pulse > hi
                && roll_mid;
      g.safe = s.throttle_pulse < lo
               && s.yaw_pulse >= SAFE_LO && s.yaw_pulse <= SAFE_HI
               && s.pitch_pulse >= SAFE_LO && s.pitch_pulse <= SAFE_HI
               && s.roll_pulse >= SAFE_LO && s.roll_pulse <= SAFE_HI;
      return g;
   endfunction

   function automatic arm_status_type advance_arming(sample_type s);
      gesture_type g;
      arm_status_type r;
      logic [TICK_W-1:0] elapsed;
      g = decode_gestures(s);
      elapsed = s.now_ms - shadow_hold_start;
      r.done = 1'b0;
      case (shadow_mode)
         MODE_DISARMED: begin
            if (g.arm) begin
               shadow_hold_start = s.now_ms;
               shadow_mode = MODE_ARMING;
            end else if (g.esc_cal) begin
               shadow_hold_start = s.now_ms;
               shadow_mode = MODE_ESC_CAL;
            end else if (g.motor) begin
               shadow_mode = MODE_MOTOR_CHECK;
            end
         end
         MODE_ESC_CAL: begin
            if (g.esc_cal && elapsed >= TICK_W'(shadow_cfg.esc_cal_hold_ms))
               shadow_cal = 1'b1;
         end
         MODE_ARMING: begin
            if (!g.arm) begin
               shadow_mode = MODE_DISARMED;
            end else if (elapsed >= TICK_W'(shadow_cfg.arm_hold_ms)) begin
               shadow_mode = MODE_ARMED_WAIT;
               r.done = 1'b1;
            end
         end
         MODE_ARMED_WAIT: begin
            if (g.safe)
               shadow_mode = MODE_ARMED;
         end
         MODE_ARMED: begin
            if (g.disarm) begin
               shadow_hold_start = s.now_ms;
               shadow_mode = MODE_DISARMING;
            end
         end
         MODE_DISARMING: begin
            if (!g.disarm)
               shadow_mode = MODE_ARMED;
            else if (elapsed >= TICK_W'(shadow_cfg.disarm_hold_ms))
               shadow_mode = MODE_DISARMED;
         end
         default: begin
         end
      endcase
      r.mode = shadow_mode;
      r.cal = shadow_cal;
      return r;
   endfunction

   function automatic logic [PULSE_W-1:0] low_pulse();
      if (shadow_cfg.stick_low_limit == '0)
         return '0;
      return PULSE_W'($urandom_range(shadow_cfg.stick_low_limit - 1, 0));
   endfunction

   function automatic logic [PULSE_W-1:0] high_pulse();
      if (shadow_cfg.stick_high_limit == '1)
         return '1;
      return PULSE_W'($urandom_range(4095, shadow_cfg.stick_high_limit + 1));
   endfunction

   function automatic logic [PULSE_W-1:0] mid_roll();
      return PULSE_W'($urandom_range(ROLL_MID_HI - 1, ROLL_MID_LO + 1));
   endfunction

   function automatic logic [PULSE_W-1:0] centered_pulse();
      return PULSE_W'($urandom_range(SAFE_HI, SAFE_LO));
   endfunction

   function automatic logic [PULSE_W-1:0] any_pulse();
      return PULSE_W'($urandom_range(4095, 0));
   endfunction

   function automatic gesture_kind_type choose_kind(arm_mode_type m);
      int r;
      gesture_kind_type other;
      r = $urandom_range(99, 0);
      other = gesture_kind_type'($urandom_range(6, 0));
      case (m)
         MODE_DISARMED:
            return r < 60 ? G_ARM : r < 70 ? G_SAFE : r < 78 ? G_DISARM :
                   r < 84 ? G_ESC : r < 90 ? G_MOTOR : G_NOISE;
         MODE_ARMING:     return r < 85 ? G_ARM : other;
         MODE_ARMED_WAIT: return r < 55 ? G_SAFE : r < 75 ? G_ARM : other;
         MODE_ARMED:      return r < 60 ? G_DISARM : other;
         MODE_DISARMING:  return r < 85 ? G_DISARM : other;
         MODE_ESC_CAL:    return r < 65 ? G_ESC : r < 80 ? G_MOTOR : other;
         default:         return other;
      endcase
   endfunction

   function automatic sample_type build_sample(gesture_kind_type kind);
      sample_type s;
      gesture_type g;
      int unsigned stride;
      stride = shadow_cfg.arm_hold_ms;
      if (shadow_cfg.disarm_hold_ms > stride) stride = shadow_cfg.disarm_hold_ms;
      if (shadow_cfg.esc_cal_hold_ms > stride) stride = shadow_cfg.esc_cal_hold_ms;
      // Now and then the tick jumps anywhere, backwards included.
      if ($urandom_range(99, 0) < 4)
         tick_ms = $urandom;
      else
         tick_ms = tick_ms + $urandom_range(stride / 4 + 8, 0);
      s.now_ms = tick_ms;
      case (kind)
         G_ARM:    s = '{low_pulse(), high_pulse(), high_pulse(), low_pulse(), tick_ms};
         G_DISARM: s = '{low_pulse(), low_pulse(), high_pulse(), high_pulse(), tick_ms};
         G_ESC:    s = '{low_pulse(), low_pulse(), high_pulse(), mid_roll(), tick_ms};
         G_MOTOR:  s = '{high_pulse(), low_pulse(), high_pulse(), mid_roll(), tick_ms};
         G_SAFE:   s = '{low_pulse(), centered_pulse(), centered_pulse(),
                         centered_pulse(), tick_ms};
         G_IDLE:   s = '{any_pulse(), any_pulse(), '0, any_pulse(), tick_ms};
         default:  s = '{any_pulse(), any_pulse(), any_pulse(), any_pulse(), tick_ms};
      endcase
      // Calibration and motor test are never left, so they stay out of reach
      // until the final phase; a pitch of zero defeats every gesture.
      if (shadow_mode == MODE_DISARMED) begin
         g = decode_gestures(s);
         if (!g.arm && (g.esc_cal || g.motor))
            s.pitch_pulse = '0;
      end
      return s;
   endfunction

   task automatic send_sample(input sample_type s, input logic typed,
                              input arm_status_type want);
      int gap;
      arm_status_type predicted;
      if ($urandom_range(31, 0) == 0)
         sender_burst = !sender_burst;
      gap = sender_burst ? 0 : $urandom_range(15, 0);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_throttle_pulse <= s.throttle_pulse;
      req_yaw_pulse <= s.yaw_pulse;
      req_pitch_pulse <= s.pitch_pulse;
      req_roll_pulse <= s.roll_pulse;
      req_now_ms <= s.now_ms;
      do @(posedge clock); while (!req_ready);
      predicted = advance_arming(s);
      status_q.push_back(typed ? want : predicted);
      words_sent++;
      if (predicted.done)
         arm_completions++;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (status_q.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      case (idx)
         CSR_ARM_HOLD:     shadow_cfg.arm_hold_ms = data;
         CSR_DISARM_HOLD:  shadow_cfg.disarm_hold_ms = data;
         CSR_ESC_CAL_HOLD: shadow_cfg.esc_cal_hold_ms = data;
         CSR_STICK_LOW:    shadow_cfg.stick_low_limit = data[PULSE_W-1:0];
         CSR_STICK_HIGH:   shadow_cfg.stick_high_limit = data[PULSE_W-1:0];
         default: begin
         end
      endcase
   endtask

   task automatic program_cfg(input int arm_ms, input int disarm_ms, input int esc_ms,
                              input int lo, input int hi, input bit with_unused);
      settle();
      csr_write(CSR_ARM_HOLD, CSR_DATA_W'(arm_ms));
      csr_write(CSR_DISARM_HOLD, CSR_DATA_W'(disarm_ms));
      csr_write(CSR_ESC_CAL_HOLD, CSR_DATA_W'(esc_ms));
      // Bits above the limit width are junk and must be dropped.
      csr_write(CSR_STICK_LOW, {4'($urandom), PULSE_W'(lo)});
      csr_write(CSR_STICK_HIGH, {4'($urandom), PULSE_W'(hi)});
      if (with_unused)
         for (int i = CSR_STICK_HIGH + 1; i < 2 ** CSR_IDX_W; i++)
            csr_write(CSR_IDX_W'(i), CSR_DATA_W'($urandom));
      csr_write_en <= 1'b0;
      settings_used++;
   endtask

   task automatic run_random(input int count);
      for (int i = 0; i < count; i++)
         send_sample(build_sample(choose_kind(shadow_mode)), 1'b0, '0);
   endtask

   // Result checking and the watchdog.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (status_q.size() == 0) begin
               mismatches++;
               $display("%0t: result word with nothing expected, state %0d",
                        $time, rsp_arm_state);
            end else begin
               due = status_q.pop_front();
               if (rsp_arm_state !== due.mode) begin
                  mismatches++;
                  $display("%0t: arm_state expected %0d actual %0d",
                           $time, due.mode, rsp_arm_state);
               end
               if (rsp_esc_cal_request !== due.cal) begin
                  mismatches++;
                  $display("%0t: esc_cal_request expected %0b actual %0b",
                           $time, due.cal, rsp_esc_cal_request);
               end
               if (rsp_arm_done_pulse !== due.done) begin
                  mismatches++;
                  $display("%0t: arm_done_pulse expected %0b actual %0b",
                           $time, due.done, rsp_arm_done_pulse);
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
            $display("stick_gesture_arming_fsm verification failed");
            $finish;
         end
      end
   end

   // Result side: random stalls, bursts, and one long hold-off that lets the
   // block fill up and push back on the sample side.
   initial begin
      int stall;
      int taken;
      bit burst;
      taken = 0;
      burst = 1'b0;
      rsp_ready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(31, 0) == 0)
            burst = !burst;
         stall = (taken == 40) ? 300 : burst ? 0 : $urandom_range(15, 0);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         taken++;
      end
   end

   initial begin
      dir_rows = '{
         '{'{12'd0, 12'd0, 12'd0, 12'd0, 32'd0}, 1'b1, '{MODE_DISARMED, 1'b0, 1'b0}},
         '{'{12'd4095, 12'd4095, 12'd4095, 12'd4095, 32'hFFFF_FFFF}, 1'b1,
           '{MODE_DISARMED, 1'b0, 1'b0}},
         '{'{12'd1100, 12'd4095, 12'd4095, 12'd0, 32'd10}, 1'b1,
           '{MODE_DISARMED, 1'b0, 1'b0}},
         '{'{12'd0, 12'd4095, 12'd1900, 12'd0, 32'd20}, 1'b1,
           '{MODE_DISARMED, 1'b0, 1'b0}},
         '{'{12'd0, 12'd0, 12'd4095, 12'd1400, 32'd30}, 1'b1,
           '{MODE_DISARMED, 1'b0, 1'b0}},
         '{'{12'd0, 12'd0, 12'd4095, 12'd1600, 32'd40}, 1'b1,
           '{MODE_DISARMED, 1'b0, 1'b0}},
         '{'{12'd4095, 12'd0, 12'd4095, 12'd1400, 32'd50}, 1'b1,
           '{MODE_DISARMED, 1'b0, 1'b0}},
         '{'{12'd0, 12'd4095, 12'd4095, 12'd0, 32'd100}, 1'b1,
           '{MODE_ARMING, 1'b0, 1'b0}},
         '{'{12'd0, 12'd4095, 12'd4095, 12'd0, 32'd1099}, 1'b1,
           '{MODE_ARMING, 1'b0, 1'b0}},
         '{'{12'd0, 12'd4095, 12'd4095, 12'd0, 32'd1100}, 1'b1,
           '{MODE_ARMED_WAIT, 1'b0, 1'b1}},
         '{'{12'd4095, 12'd0, 12'd4095, 12'd1500, 32'd1200}, 1'b1,
           '{MODE_ARMED_WAIT, 1'b0, 1'b0}},
         '{'{12'd0, 12'd1449, 12'd1500, 12'd1500, 32'd1300}, 1'b1,
           '{MODE_ARMED_WAIT, 1'b0, 1'b0}},
         '{'{12'd0, 12'd1450, 12'd1550, 12'd1500, 32'd1400}, 1'b1,
           '{MODE_ARMED, 1'b0, 1'b0}},
         '{'{12'd0, 12'd0, 12'd4095, 12'd4095, 32'd5000}, 1'b1,
           '{MODE_DISARMING, 1'b0, 1'b0}},
         '{'{12'd1500, 12'd0, 12'd4095, 12'd4095, 32'd5100}, 1'b1,
           '{MODE_ARMED, 1'b0, 1'b0}},
         '{'{12'd0, 12'd0, 12'd4095, 12'd4095, 32'd6000}, 1'b1,
           '{MODE_DISARMING, 1'b0, 1'b0}},
         '{'{12'd0, 12'd0, 12'd4095, 12'd4095, 32'd6999}, 1'b1,
           '{MODE_DISARMING, 1'b0, 1'b0}},
         '{'{12'd0, 12'd0, 12'd4095, 12'd4095, 32'd7000}, 1'b1,
           '{MODE_DISARMED, 1'b0, 1'b0}},
         '{'{12'd0, 12'd4095, 12'd4095, 12'd0, 32'hFFFF_FF00}, 1'b1,
           '{MODE_ARMING, 1'b0, 1'b0}},
         '{'{12'd0, 12'd4095, 12'd4095, 12'd0, 32'h0000_02E8}, 1'b1,
           '{MODE_ARMED_WAIT, 1'b0, 1'b1}},
         '{'{12'd0, 12'd1550, 12'd1450, 12'd1450, 32'h0000_0300}, 1'b1,
           '{MODE_ARMED, 1'b0, 1'b0}},
         '{'{12'd0, 12'd0, 12'd4095, 12'd4095, 32'h0000_0400}, 1'b1,
           '{MODE_DISARMING, 1'b0, 1'b0}},
         '{'{12'd0, 12'd0, 12'd4095, 12'd4095, 32'h0000_03FF}, 1'b1,
           '{MODE_DISARMED, 1'b0, 1'b0}},
         '{'{12'd0, 12'd4095, 12'd4095, 12'd0, 32'h0000_0500}, 1'b0,
           '{MODE_DISARMED, 1'b0, 1'b0}},
         '{'{12'd2048, 12'd2048, 12'd2048, 12'd2048, 32'h0000_0501}, 1'b0,
           '{MODE_DISARMED, 1'b0, 1'b0}}
      };
      clock = 1'b0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_throttle_pulse <= '0;
      req_yaw_pulse <= '0;
      req_pitch_pulse <= '0;
      req_roll_pulse <= '0;
      req_now_ms <= '0;
      csr_write_en <= 1'b0;
      csr_index <= '0;
      csr_write_data <= '0;
      shadow_cfg = '{ARM_HOLD_RST, DISARM_HOLD_RST, ESC_CAL_HOLD_RST,
                     STICK_LOW_RST, STICK_HIGH_RST};
      shadow_mode = MODE_DISARMED;
      shadow_hold_start = '0;
      shadow_cal = 1'b0;
      mismatches = 0;
      quiet_cycles = 0;
      words_sent = 0;
      arm_completions = 0;
      settings_used = 1;
      sender_burst = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i])
         send_sample(dir_rows[i].smp, dir_rows[i].typed, dir_rows[i].want);

      tick_ms = $urandom;
      run_random(150);
      program_cfg(0, 0, 0, 1100, 1900, 1'b1);
      run_random(150);
      program_cfg(65535, 65535, 65535, 1, 4094, 1'b0);
      run_random(120);
      program_cfg($urandom_range(2000, 0), $urandom_range(2000, 0),
                  $urandom_range(2000, 0), 4095, 0, 1'b0);
      run_random(120);
      program_cfg($urandom_range(2000, 0), $urandom_range(2000, 0),
                  $urandom_range(2000, 0), 0, 4095, 1'b0);
      run_random(40);
      program_cfg($urandom_range(3000, 0), $urandom_range(3000, 0),
                  $urandom_range(3000, 0), $urandom_range(1300, 900),
                  $urandom_range(2100, 1700), 1'b0);
      run_random(150);

      // Walk back to disarmed, then enter calibration with crossed limits so
      // that arm beats calibration and calibration beats motor test.
      while (shadow_mode != MODE_DISARMED)
         send_sample(build_sample(shadow_mode == MODE_ARMING ? G_IDLE :
                                  shadow_mode == MODE_ARMED_WAIT ? G_SAFE : G_DISARM),
                     1'b0, '0);
      program_cfg(shadow_cfg.arm_hold_ms, shadow_cfg.disarm_hold_ms,
                  shadow_cfg.esc_cal_hold_ms, 4095, 0, 1'b0);
      tick_ms = tick_ms + 1;
      send_sample('{12'd2000, 12'd2000, 12'd4095, 12'd1500, tick_ms}, 1'b1,
                  '{MODE_ARMING, 1'b0, 1'b0});
      send_sample('{12'd2000, 12'd0, 12'd4095, 12'd1500, tick_ms}, 1'b1,
                  '{MODE_DISARMED, 1'b0, 1'b0});
      send_sample('{12'd2000, 12'd0, 12'd4095, 12'd1500, tick_ms}, 1'b1,
                  '{MODE_ESC_CAL, 1'b0, 1'b0});
      program_cfg($urandom_range(3000, 0), $urandom_range(3000, 0),
                  $urandom_range(3000, 200), 1100, 1900, 1'b0);
      run_random(120);
      settle();

      $display("Sent %0d sample words over %0d register settings, %0d arming completions.",
               words_sent, settings_used, arm_completions);
      $display("Run ended in calibration with the request flag at %0b; %0d mismatches.",
               shadow_cal, mismatches);
      if (mismatches == 0 && status_q.size() == 0)
         $display("stick_gesture_arming_fsm verification clean");
      else
         $display("stick_gesture_arming_fsm verification failed");
      $finish;
   end

endmodule
